// ===== rtl/core/rgr_pkg.sv =====
package rgr_pkg;

    localparam int SCREEN_WIDTH_DEF  = 144;
    localparam int SCREEN_HEIGHT_DEF = 168;

    localparam int CW      = 11;   // coordinate field width
    localparam int XW      = 12;   // coordinate width after clamping to the screen
    localparam int ADDR_IN = 14;   // read_address field width
    localparam int MAGW    = 18;   // |dy| * 100 fits here
    localparam int DENW    = 11;   // span of x (up to the screen width) and |dy| (up to 2047)
    localparam int QW      = 22;   // accumulated quotient of slope * step / 100
    localparam int YW      = 24;   // line y before the screen check
    localparam int REMW    = 7;    // remainder of a divide by 100
    localparam int SLOPE_SCALE = 100;
    // floor(n / 100) == (n * SLOPE_RECIP) >> SLOPE_SHIFT for every n below 2**MAGW
    localparam int RECIPW      = 19;
    localparam logic [RECIPW-1:0] SLOPE_RECIP = 19'd335545;
    localparam int SLOPE_SHIFT = 25;

    typedef enum logic [1:0] {
        CMD_POINT = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_DRAW_RED    = 3'd0,
        REG_DRAW_GREEN  = 3'd1,
        REG_DRAW_BLUE   = 3'd2,
        REG_CLEAR_RED   = 3'd3,
        REG_CLEAR_GREEN = 3'd4,
        REG_CLEAR_BLUE  = 3'd5
    } t_reg;

    localparam int NUM_REGS = 6;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_BRUSH,
        ST_SETUP,
        ST_DIV_A,
        ST_WAIT_A,
        ST_DIV_B,
        ST_WAIT_B,
        ST_RUN,
        ST_FILL,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        FB_NONE  = 2'd0,
        FB_PIXEL = 2'd1,
        FB_FILL  = 2'd2,
        FB_READ  = 2'd3
    } t_fb_op;

    typedef struct packed {
        t_fb_op     op;
        logic       low;   // odd x: low nibble
        logic [7:0] data;  // fill byte, or shade in the low nibble
    } t_fb_req;

    function automatic logic [4:0] shade_of(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [10:0] sum;
        sum = 11'(r) * 11'd3 + {1'b0, g, 2'b00} + 11'(b);
        return sum[10:6];
    endfunction

endpackage

// ===== rtl/core/rgr_div.sv =====
module rgr_div
    import rgr_pkg::*;
#(
    parameter int NW = MAGW,
    parameter int DW = DENW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [NW-1:0]   r_q, n_q;
    logic [DW-1:0]   r_r, n_r;
    logic [DW-1:0]   r_d, n_d;
    logic [DW:0]     trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        trial  = {r_r, r_q[NW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(NW);
            n_q    = i_num;
            n_r    = '0;
            n_d    = i_den;
        end else if (r_busy) begin
            // one quotient bit per cycle
            if (trial >= {1'b0, r_d}) begin
                n_r = DW'(trial - {1'b0, r_d});
                n_q = {r_q[NW-2:0], 1'b1};
            end else begin
                n_r = trial[DW-1:0];
                n_q = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ===== rtl/core/rgr_fb.sv =====
module rgr_fb
    import rgr_pkg::*;
#(
    parameter int DEPTH = (SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF + 1) / 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_fb_req       i_req,
    input  logic [AW-1:0] i_addr,
    output logic          o_ready,
    output logic          o_rd_valid,
    output logic [7:0]    o_rd_data
);
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_q;
    logic          r_pend;
    logic          r_rdv;
    logic [AW-1:0] r_waddr;
    logic          r_low;
    logic [3:0]    r_shade;
    logic [7:0]    merged;

    assign merged = r_low ? {r_q[7:4], r_shade} : {r_shade, r_q[3:0]};

    // pixel: read in the request cycle, write the merged byte in the next
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_mem[r_waddr] <= merged;
        end else if (i_req.op == FB_FILL) begin
            r_mem[i_addr] <= i_req.data;
        end
        r_q     <= r_mem[i_addr];
        r_waddr <= i_addr;
        r_low   <= i_req.low;
        r_shade <= i_req.data[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_rdv  <= 1'b0;
        end else begin
            r_pend <= (i_req.op == FB_PIXEL) && !r_pend;
            r_rdv  <= (i_req.op == FB_READ) && !r_pend;
        end
    end

    assign o_ready    = !r_pend;
    assign o_rd_valid = r_rdv;
    assign o_rd_data  = r_q;
endmodule

// ===== rtl/core/packed_gray_raster_engine.sv =====
// Packed 4-bit grayscale raster engine, two pixels per framebuffer byte.
// Channels: a command stream in (s_axis_*, command in tuser), a result stream
// out (m_axis_*, one byte per command) and a register write port (i_cfg_*,
// always ready) for the draw and clear colors.
// Every command returns exactly one beat: the addressed byte for a read
// inside the framebuffer, zero for point, line, clear and any other read.
// Steps (one framebuffer port, read-modify-write per pixel):
//   point: a 3x3 brush of 9 pixels; read: one framebuffer read;
//   clear: one byte per cycle over all (W*H+1)/2 bytes;
//   line: two brushes (2*9 pixels), then setup and slope division, then
//   one read-modify-write per on-screen line pixel, up to W pixels.
// Commands run one at a time; s_axis_tready is high only while idle.
// After reset the block writes zero into all (W*H+1)/2 bytes, one per cycle,
// before it takes the first command (12096 bytes at 144 x 168).
// A result waits in the output register while m_axis_tready is low; the
// next command may be accepted meanwhile and holds at its end until the
// output register frees up.
module packed_gray_raster_engine
    import rgr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [10:0] start_x, [21:11] start_y, [32:22] end_x, [43:33] end_y,
    // [57:44] read_address, [63:58] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    localparam int DEPTH = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [XW-1:0] SW = XW'(SCREEN_WIDTH);
    localparam logic signed [XW-1:0] SH = XW'(SCREEN_HEIGHT);

    typedef logic signed [XW-1:0] t_crd;

    logic [7:0] r_cfg [NUM_REGS];

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    t_crd   r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1, r_xc, n_xc;
    logic   r_end, n_end;
    logic [1:0] r_bi, n_bi, r_bj, n_bj;
    logic [AW-1:0] r_addr, n_addr;
    logic   r_neg, n_neg;
    logic [DENW-1:0] r_dx, n_dx;
    logic [MAGW-1:0] r_num, n_num, r_slope, n_slope, r_sq, n_sq;
    logic [REMW-1:0] r_sr, n_sr, r_rm, n_rm;
    logic [QW-1:0]   r_qm, n_qm;
    logic [7:0]  r_res, n_res;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_data, n_out_data;

    t_fb_req       fb_req;
    logic [AW-1:0] fb_addr;
    logic          fb_ready, fb_rd_valid;
    logic [7:0]    fb_rd_data;

    logic            div_start, div_done;
    logic [MAGW-1:0] div_num, div_quo;
    logic [DENW-1:0] div_den;

    logic [MAGW+RECIPW-1:0] recip_prod;
    logic [MAGW-1:0]        slope_quo, slope_rem;

    logic [3:0] draw_shade;
    logic [4:0] clr_c;
    logic [7:0] clr_byte;

    t_crd in_sx, in_sy, in_ex, in_ey;
    t_crd bx, by, pix_x, pix_y;
    logic brush_ok;
    t_crd x0c, x1c, y0c, y1c;
    logic signed [XW:0] dy;
    logic [DENW-1:0] dy_mag;
    logic signed [YW-1:0] line_y;
    logic line_on;
    logic [REMW:0] rm_sum;
    logic [AW:0] lin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_cfg[i] <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_DRAW_RED:    r_cfg[REG_DRAW_RED]    <= i_cfg_data;
                REG_DRAW_GREEN:  r_cfg[REG_DRAW_GREEN]  <= i_cfg_data;
                REG_DRAW_BLUE:   r_cfg[REG_DRAW_BLUE]   <= i_cfg_data;
                REG_CLEAR_RED:   r_cfg[REG_CLEAR_RED]   <= i_cfg_data;
                REG_CLEAR_GREEN: r_cfg[REG_CLEAR_GREEN] <= i_cfg_data;
                REG_CLEAR_BLUE:  r_cfg[REG_CLEAR_BLUE]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign draw_shade = 4'(shade_of(r_cfg[REG_DRAW_RED], r_cfg[REG_DRAW_GREEN],
                                    r_cfg[REG_DRAW_BLUE]));
    assign clr_c      = shade_of(r_cfg[REG_CLEAR_RED], r_cfg[REG_CLEAR_GREEN],
                                 r_cfg[REG_CLEAR_BLUE]);
    assign clr_byte   = {clr_c[3:0], 4'b0000} | {3'b000, clr_c};

    assign in_sx = XW'($signed(s_axis_tdata[10:0]));
    assign in_sy = XW'($signed(s_axis_tdata[21:11]));
    assign in_ex = XW'($signed(s_axis_tdata[32:22]));
    assign in_ey = XW'($signed(s_axis_tdata[43:33]));

    assign bx = r_end ? r_x1 : r_x0;
    assign by = r_end ? r_y1 : r_y0;
    assign brush_ok = (bx >= t_crd'(1)) && (bx < SW - t_crd'(1)) &&
                      (by >= t_crd'(1)) && (by < SH - t_crd'(1));

    assign x0c = (r_x0 < t_crd'(0)) ? t_crd'(0) : r_x0;
    assign x1c = (r_x1 > SW) ? SW : r_x1;
    assign y0c = (r_y0 < t_crd'(0)) ? t_crd'(0) : r_y0;
    assign y1c = (r_y1 > SH) ? SH : r_y1;
    assign dy  = (XW+1)'(y1c) - (XW+1)'(y0c);
    assign dy_mag = dy[XW] ? DENW'(-dy) : DENW'(dy);

    // split the slope into slope/100 and slope%100 by reciprocal multiply
    assign recip_prod = (MAGW+RECIPW)'(r_slope) * (MAGW+RECIPW)'(SLOPE_RECIP);
    assign slope_quo  = MAGW'(recip_prod >> SLOPE_SHIFT);
    assign slope_rem  = r_slope - MAGW'(r_sq * MAGW'(SLOPE_SCALE));

    assign line_y  = r_neg ? (YW'(r_y0) - $signed({2'b00, r_qm}))
                           : (YW'(r_y0) + $signed({2'b00, r_qm}));
    assign line_on = (line_y >= YW'(0)) && (line_y < YW'(SH));
    assign rm_sum  = {1'b0, r_rm} + {1'b0, r_sr};

    always_comb begin
        if (r_state == ST_RUN) begin
            pix_x = r_xc;
            pix_y = XW'(line_y);
        end else begin
            pix_x = bx + t_crd'(r_bi) - t_crd'(1);
            pix_y = by + t_crd'(r_bj) - t_crd'(1);
        end
    end

    assign lin = (AW+1)'($unsigned(pix_y)) * (AW+1)'(SCREEN_WIDTH) +
                 (AW+1)'($unsigned(pix_x));

    always_comb begin
        fb_req  = '{op: FB_NONE, low: pix_x[0], data: {4'b0000, draw_shade}};
        fb_addr = lin[AW:1];
        case (r_state)
            ST_INIT: begin
                fb_req.op   = FB_FILL;
                fb_req.data = 8'h00;
                fb_addr     = r_addr;
            end
            ST_FILL: begin
                fb_req.op   = FB_FILL;
                fb_req.data = clr_byte;
                fb_addr     = r_addr;
            end
            ST_BRUSH: if (brush_ok && fb_ready) fb_req.op = FB_PIXEL;
            ST_RUN:   if (line_on && fb_ready) fb_req.op = FB_PIXEL;
            ST_READ: begin
                fb_addr = r_addr;
                if (fb_ready) fb_req.op = FB_READ;
            end
            default: ;
        endcase
    end

    assign div_start = (r_state == ST_DIV_A);
    assign div_num   = r_num;
    assign div_den   = r_dx;

    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_x0 = r_x0; n_y0 = r_y0; n_x1 = r_x1; n_y1 = r_y1; n_xc = r_xc;
        n_end = r_end; n_bi = r_bi; n_bj = r_bj;
        n_addr = r_addr;
        n_neg = r_neg; n_dx = r_dx; n_num = r_num; n_slope = r_slope;
        n_sq = r_sq; n_sr = r_sr; n_qm = r_qm; n_rm = r_rm;
        n_res = r_res;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        case (r_state)
            ST_INIT: begin
                if (fb_ready) begin
                    n_addr = r_addr + 1'b1;
                    if (r_addr == AW'(DEPTH - 1)) begin
                        n_addr  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd = t_cmd'(s_axis_tuser);
                    n_res = 8'h00;
                    n_end = 1'b0;
                    n_bi  = '0;
                    n_bj  = '0;
                    n_addr = '0;
                    // order line ends so x0 <= x1
                    if (t_cmd'(s_axis_tuser) == CMD_LINE && in_sx > in_ex) begin
                        n_x0 = in_ex; n_y0 = in_ey; n_x1 = in_sx; n_y1 = in_sy;
                    end else begin
                        n_x0 = in_sx; n_y0 = in_sy; n_x1 = in_ex; n_y1 = in_ey;
                    end
                    case (t_cmd'(s_axis_tuser))
                        CMD_POINT, CMD_LINE: n_state = ST_BRUSH;
                        CMD_CLEAR:           n_state = ST_FILL;
                        CMD_READ: begin
                            n_addr = AW'(s_axis_tdata[57:44]);
                            if (32'(s_axis_tdata[57:44]) < 32'(DEPTH)) begin
                                n_state = ST_READ;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_BRUSH: begin
                if (!brush_ok || (fb_ready && r_bi == 2'd2 && r_bj == 2'd2)) begin
                    n_bi = '0;
                    n_bj = '0;
                    if (r_cmd != CMD_LINE) begin
                        n_state = ST_DONE;
                    end else if (!r_end) begin
                        n_end = 1'b1;
                    end else begin
                        n_state = ST_SETUP;
                    end
                end else if (fb_ready) begin
                    if (r_bi == 2'd2) begin
                        n_bi = '0;
                        n_bj = r_bj + 1'b1;
                    end else begin
                        n_bi = r_bi + 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                n_x0  = x0c;
                n_x1  = x1c;
                n_y0  = y0c;
                n_neg = dy[XW];
                n_num = MAGW'(dy_mag) * MAGW'(SLOPE_SCALE);
                n_dx  = DENW'(x1c - x0c);
                n_state = (x0c < x1c) ? ST_DIV_A : ST_DONE;
            end
            ST_DIV_A: n_state = ST_WAIT_A;
            ST_WAIT_A: begin
                if (div_done) begin
                    n_slope = div_quo;
                    n_state = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                n_sq    = slope_quo;
                n_state = ST_WAIT_B;
            end
            ST_WAIT_B: begin
                n_sr = REMW'(slope_rem);
                n_xc = r_x0;
                n_qm = '0;
                n_rm = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (!line_on || fb_ready) begin
                    // advance y by slope/100 with the remainder carried
                    if (rm_sum >= (REMW+1)'(SLOPE_SCALE)) begin
                        n_rm = REMW'(rm_sum - (REMW+1)'(SLOPE_SCALE));
                        n_qm = r_qm + QW'(r_sq) + QW'(1);
                    end else begin
                        n_rm = REMW'(rm_sum);
                        n_qm = r_qm + QW'(r_sq);
                    end
                    n_xc = r_xc + t_crd'(1);
                    if (r_xc == r_x1 - t_crd'(1)) n_state = ST_DONE;
                end
            end
            ST_FILL: begin
                if (fb_ready) begin
                    n_addr = r_addr + 1'b1;
                    if (r_addr == AW'(DEPTH - 1)) n_state = ST_DONE;
                end
            end
            ST_READ: if (fb_ready) n_state = ST_READ_WAIT;
            ST_READ_WAIT: begin
                if (fb_rd_valid) begin
                    n_res   = fb_rd_data;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_end       <= 1'b0;
            r_bi        <= '0;
            r_bj        <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            r_end       <= n_end;
            r_bi        <= n_bi;
            r_bj        <= n_bj;
        end
        r_cmd <= n_cmd;
        r_x0 <= n_x0; r_y0 <= n_y0; r_x1 <= n_x1; r_y1 <= n_y1; r_xc <= n_xc;
        r_neg <= n_neg; r_dx <= n_dx; r_num <= n_num; r_slope <= n_slope;
        r_sq <= n_sq; r_sr <= n_sr; r_qm <= n_qm; r_rm <= n_rm;
        r_res <= n_res;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    rgr_div #(.NW(MAGW), .DW(DENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    rgr_fb #(.DEPTH(DEPTH), .AW(AW)) u_fb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (fb_req),
        .i_addr     (fb_addr),
        .o_ready    (fb_ready),
        .o_rd_valid (fb_rd_valid),
        .o_rd_data  (fb_rd_data)
    );
endmodule

// ===== rtl/core/rgr_chk.sv =====
module rgr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    logic [1:0] r_pend;
    logic       in_beat, out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // commands taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != 2'd0)
        else $error("result beat without a pending command");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two commands outstanding");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !s_axis_tready)
        else $error("command taken while another is running");
endmodule

bind packed_gray_raster_engine rgr_chk u_rgr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
